/* rtl/core/audio_packet_peak_level_meter_macros.svh */
// Assertion helpers shared by the meter modules.
`ifndef AUDIO_PACKET_PEAK_LEVEL_METER_MACROS_SVH
`define AUDIO_PACKET_PEAK_LEVEL_METER_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define APM_ASSERT_NOW(label, pre, post) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error("apm assertion failed");

// Next-cycle implication, checked out of reset.
`define APM_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error("apm assertion failed");

`endif

/* rtl/core/apm_pkg.sv */
`default_nettype none
package apm_pkg;

    localparam int SAMPLE_W = 32;
    localparam int KIND_W   = 2;
    localparam int BPS_W    = 6;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = BPS_W;

    localparam logic [KIND_W-1:0] KIND_PCM   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FLOAT = 2'd1;

    localparam logic [BPS_W-1:0] BPS_16    = 6'd16;
    localparam logic [BPS_W-1:0] BPS_24    = 6'd24;
    localparam logic [BPS_W-1:0] BPS_32    = 6'd32;
    localparam logic [BPS_W-1:0] BPS_RESET = BPS_16;

    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_KIND     = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BITS_PER_SAMPLE = 1'b1;

    // Float exponent at which the Q1.31 value equals the 24-bit mantissa.
    localparam logic [7:0] FLT_EXP_UNITY = 8'd119;
    localparam logic [7:0] FLT_EXP_SAT   = 8'd128;
    localparam logic [7:0] FLT_EXP_SPEC  = 8'd255;

    typedef struct packed {
        logic                valid;  // low for a float NaN
        logic [SAMPLE_W-1:0] value;
    } t_mag;

endpackage
`default_nettype wire

/* rtl/core/apm_in_if.sv */
`default_nettype none
interface apm_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] raw_sample;
    logic        packet_silent;
    logic        last_sample;

    modport source (output valid, output raw_sample, output packet_silent,
                    output last_sample, input ready);
    modport sink   (input valid, input raw_sample, input packet_silent,
                    input last_sample, output ready);
endinterface
`default_nettype wire

/* rtl/core/apm_out_if.sv */
`default_nettype none
interface apm_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] packet_peak;
    logic [31:0] smoothed_level;

    modport source (output valid, output packet_peak, output smoothed_level, input ready);
    modport sink   (input valid, input packet_peak, input smoothed_level, output ready);
endinterface
`default_nettype wire

/* rtl/core/apm_decode.sv */
`default_nettype none
module apm_decode (
    input  wire logic [apm_pkg::KIND_W-1:0]   i_kind,
    input  wire logic [apm_pkg::BPS_W-1:0]    i_bps,
    input  wire logic [apm_pkg::SAMPLE_W-1:0] i_raw,
    input  wire logic                         i_silent,
    output apm_pkg::t_mag                     o_mag
);
    import apm_pkg::*;

    logic [15:0]         pcm16_neg;
    logic [23:0]         pcm24_neg;
    logic [SAMPLE_W-1:0] pcm_mag;
    logic [7:0]          flt_exp;
    logic [23:0]         flt_man;
    logic [7:0]          flt_lsh;
    logic [7:0]          flt_rsh;
    logic [SAMPLE_W-1:0] flt_wide;
    logic [SAMPLE_W-1:0] flt_mag;
    logic                flt_nan;

    always_comb begin
        pcm16_neg = 16'd0 - i_raw[15:0];
        pcm24_neg = 24'd0 - i_raw[23:0];
        unique case (i_bps)
            BPS_16:  pcm_mag = {(i_raw[15] ? pcm16_neg : i_raw[15:0]), 16'd0};
            BPS_24:  pcm_mag = {(i_raw[23] ? pcm24_neg : i_raw[23:0]), 8'd0};
            BPS_32:  pcm_mag = i_raw[31] ? (32'd0 - i_raw) : i_raw;
            default: pcm_mag = '0;
        endcase
    end

    always_comb begin
        flt_exp  = i_raw[30:23];
        flt_man  = {1'b1, i_raw[22:0]};
        flt_lsh  = flt_exp - FLT_EXP_UNITY;
        flt_rsh  = FLT_EXP_UNITY - flt_exp;
        flt_wide = {8'd0, flt_man};
        flt_nan  = 1'b0;
        priority if (flt_exp == FLT_EXP_SPEC) begin
            flt_nan = (i_raw[22:0] != 23'd0);
            flt_mag = flt_nan ? '0 : '1;
        end else if (flt_exp >= FLT_EXP_SAT) begin
            flt_mag = '1;
        end else if (flt_exp == 8'd0) begin
            // subnormals read as zero
            flt_mag = '0;
        end else if (flt_exp >= FLT_EXP_UNITY) begin
            flt_mag = flt_wide << flt_lsh[3:0];
        end else if (flt_rsh >= 8'd32) begin
            flt_mag = '0;
        end else begin
            flt_mag = flt_wide >> flt_rsh[4:0];
        end
    end

    always_comb begin
        o_mag.valid = 1'b1;
        o_mag.value = '0;
        if (!i_silent) begin
            if (i_kind == KIND_FLOAT && i_bps == BPS_32) begin
                o_mag.valid = !flt_nan;
                o_mag.value = flt_mag;
            end else if (i_kind == KIND_PCM) begin
                o_mag.value = pcm_mag;
            end
        end
    end

endmodule
`default_nettype wire

/* rtl/core/apm_meter.sv */
`default_nettype none
`include "audio_packet_peak_level_meter_macros.svh"
module apm_meter (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_item_valid,
    input  wire logic   i_last,
    input  wire apm_pkg::t_mag i_mag,
    output logic        o_take,
    apm_out_if.source   o_out
);
    import apm_pkg::*;

    logic [SAMPLE_W-1:0] r_peak;
    logic [SAMPLE_W-1:0] r_level;
    logic                r_out_valid;
    logic [SAMPLE_W-1:0] r_out_peak;
    logic [SAMPLE_W-1:0] n_peak;
    logic [SAMPLE_W:0]   n_sum;
    logic [SAMPLE_W-1:0] n_level;

    // A packet end needs the result register free; other beats never wait.
    assign o_take = i_item_valid && (!i_last || !r_out_valid || o_out.ready);

    always_comb begin
        n_peak  = (i_mag.valid && i_mag.value > r_peak) ? i_mag.value : r_peak;
        n_sum   = {1'b0, r_level} + {1'b0, n_peak};
        n_level = n_sum[SAMPLE_W:1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_peak      <= '0;
            r_level     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_take) begin
                r_peak <= i_last ? '0 : n_peak;
                if (i_last) begin
                    r_level <= n_level;
                end
            end
            if (o_take && i_last) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take && i_last) begin
            r_out_peak <= n_peak;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.packet_peak    = r_out_peak;
    assign o_out.smoothed_level = r_level;

    `APM_ASSERT_NEXT(a_end_shows_result, o_take && i_last, r_out_valid)
    `APM_ASSERT_NEXT(a_end_clears_peak, o_take && i_last, r_peak == '0)
    `APM_ASSERT_NEXT(a_level_is_mean, o_take && i_last,
        r_level <= $past(r_level) || r_level <= r_out_peak)

endmodule
`default_nettype wire

/* rtl/core/audio_packet_peak_level_meter.sv */
//  channel   dir  beat contents
//  i_in      in   raw_sample[31:0], packet_silent, last_sample
//  o_out     out  packet_peak[31:0], smoothed_level[31:0] (packet end only)
//  i_cfg_*   in   register write: index 0 sample_kind, 1 bits_per_sample
//
//  One beat per cycle while no packet end is held: a beat is latched in the
//  input register, then decoded and folded into the running peak when the
//  meter takes it; a packet end's result is registered at that same take.
//  Reset clears peak, level and valid flags and sets the config registers to
//  their defaults. Non-final beats advance even while a result is stalled; a
//  packet end waits in the input register until the result register is free.
`default_nettype none
`include "audio_packet_peak_level_meter_macros.svh"
module audio_packet_peak_level_meter (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [apm_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [apm_pkg::CFG_DATA_W-1:0] i_cfg_data,
    apm_in_if.sink                              i_in,
    apm_out_if.source                           o_out
);
    import apm_pkg::*;

    logic [KIND_W-1:0]   r_kind;
    logic [BPS_W-1:0]    r_bps;
    logic                r_s1_valid;
    logic [SAMPLE_W-1:0] r_s1_raw;
    logic                r_s1_silent;
    logic                r_s1_last;
    logic                take;
    t_mag                mag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind <= KIND_PCM;
            r_bps  <= BPS_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_SAMPLE_KIND:     r_kind <= i_cfg_data[KIND_W-1:0];
                CFG_BITS_PER_SAMPLE: r_bps  <= i_cfg_data[BPS_W-1:0];
                default: ;
            endcase
        end
    end

    assign i_in.ready = !r_s1_valid || take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_in.valid && i_in.ready) begin
            r_s1_valid <= 1'b1;
        end else if (take) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_s1_raw    <= i_in.raw_sample;
            r_s1_silent <= i_in.packet_silent;
            r_s1_last   <= i_in.last_sample;
        end
    end

    apm_decode u_decode (
        .i_kind   (r_kind),
        .i_bps    (r_bps),
        .i_raw    (r_s1_raw),
        .i_silent (r_s1_silent),
        .o_mag    (mag)
    );

    apm_meter u_meter (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (r_s1_valid),
        .i_last       (r_s1_last),
        .i_mag        (mag),
        .o_take       (take),
        .o_out        (o_out)
    );

    `APM_ASSERT_NEXT(a_held_beat_kept, r_s1_valid && !take, r_s1_valid)
    `APM_ASSERT_NOW(a_take_needs_beat, take, r_s1_valid)
    `APM_ASSERT_NEXT(a_held_beat_stable, r_s1_valid && !take,
        $stable(r_s1_raw) && $stable(r_s1_last))

endmodule
`default_nettype wire

/* test/tb_audio_packet_peak_level_meter.sv */
`default_nettype none
module tb_audio_packet_peak_level_meter;
    timeunit 1ns;
    timeprecision 1ps;

    import apm_pkg::*;

    typedef struct {
        logic [31:0] raw;
        logic        silent;
        logic        last;
        int unsigned gap;
    } t_sample_beat;

    typedef struct {
        logic [31:0] peak;
        logic [31:0] level;
    } t_meter_report;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    apm_in_if  in_ch ();
    apm_out_if out_ch ();

    audio_packet_peak_level_meter dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    // Shadow of the meter: registers and running state
    logic [KIND_W-1:0] cfg_kind  = KIND_PCM;
    logic [BPS_W-1:0]  cfg_width = BPS_RESET;
    logic [31:0]       peak_so_far = '0;
    logic [31:0]       level_now   = '0;
    t_meter_report     reports_due[$];

    t_sample_beat beats_to_send[$];
    t_sample_beat beat_now;
    logic         beat_held = 1'b0;
    int unsigned  beats_queued = 0;
    int unsigned  beats_taken  = 0;
    logic         in_took  = 1'b0;
    logic         out_took = 1'b0;
    logic         tx_calm  = 1'b0;
    logic         rx_calm  = 1'b0;
    logic         rx_hold_req = 1'b0;
    int unsigned  rx_hold  = 0;
    int unsigned  rx_stall = 0;
    int unsigned  mismatches = 0;

    // Q1.31 magnitude of a float32; bit 32 low marks a NaN
    function automatic logic [32:0] float_q131(input logic [31:0] bits);
        logic [7:0]  ex;
        logic [23:0] frac;
        ex   = bits[30:23];
        frac = {1'b1, bits[22:0]};
        if (ex == FLT_EXP_SPEC) begin
            return (bits[22:0] != '0) ? 33'd0 : {1'b1, 32'hFFFF_FFFF};
        end
        if (ex >= FLT_EXP_SAT) return {1'b1, 32'hFFFF_FFFF};
        if (ex == 8'd0) return {1'b1, 32'd0};
        if (ex >= FLT_EXP_UNITY) return {1'b1, 32'(frac) << (ex - FLT_EXP_UNITY)};
        return {1'b1, 32'(frac) >> (FLT_EXP_UNITY - ex)};
    endfunction

    function automatic logic [31:0] pcm_q131(input logic [31:0] raw,
                                             input logic [BPS_W-1:0] width);
        logic [16:0] a16;
        logic [24:0] a24;
        case (width)
            BPS_16: begin
                a16 = raw[15] ? 17'h10000 - {1'b0, raw[15:0]} : {1'b0, raw[15:0]};
                return {a16[15:0], 16'd0};
            end
            BPS_24: begin
                a24 = raw[23] ? 25'h100_0000 - {1'b0, raw[23:0]} : {1'b0, raw[23:0]};
                return {a24[23:0], 8'd0};
            end
            BPS_32: return raw[31] ? 32'd0 - raw : raw;
            default: return 32'd0;
        endcase
    endfunction

    task automatic fold_sample(input logic [31:0] raw, input logic silent,
                               input logic last);
        logic [32:0] mag;
        logic [32:0] sum;
        mag = {1'b1, 32'd0};
        if (!silent) begin
            if (cfg_kind == KIND_FLOAT && cfg_width == BPS_32) begin
                mag = float_q131(raw);
            end else if (cfg_kind == KIND_PCM) begin
                mag = {1'b1, pcm_q131(raw, cfg_width)};
            end
        end
        if (mag[32] && mag[31:0] > peak_so_far) peak_so_far = mag[31:0];
        if (last) begin
            sum = {1'b0, level_now} + {1'b0, peak_so_far};
            level_now = sum[32:1];
            reports_due.push_back('{peak_so_far, level_now});
            peak_so_far = '0;
        end
    endtask

    task automatic queue_beat(input logic [31:0] raw, input logic silent,
                              input logic last, input int unsigned gap);
        beats_to_send.push_back('{raw, silent, last, gap});
        beats_queued++;
    endtask

    // Hold until every beat is taken and every report seen, then let the pipe drain
    task automatic wait_drained();
        do @(negedge i_clk);
        while (beats_taken != beats_queued || reports_due.size() != 0);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_registers(input logic [CFG_DATA_W-1:0] kind_word,
                                   input logic [CFG_DATA_W-1:0] width_word);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_index <= CFG_SAMPLE_KIND;
        cfg_data  <= kind_word;
        cfg_kind   = kind_word[KIND_W-1:0];
        @(negedge i_clk);
        cfg_index <= CFG_BITS_PER_SAMPLE;
        cfg_data  <= width_word;
        cfg_width  = width_word[BPS_W-1:0];
        @(negedge i_clk);
        cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [BPS_W-1:0] pick_width();
        case ($urandom_range(0, 5))
            0: return 6'd0;
            1: return 6'd63;
            2: return BPS_16;
            3: return BPS_24;
            4: return BPS_32;
            default: return 6'($urandom_range(0, 63));
        endcase
    endfunction

    function automatic logic [31:0] random_sample();
        logic [31:0] corner_words[8] = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000,
                                         32'h7FFF_FFFF, 32'h0000_8000, 32'h0000_7FFF,
                                         32'h0080_0000, 32'h007F_FFFF};
        logic [31:0] amp;
        logic [7:0]  ex;
        if ($urandom_range(0, 5) == 0) return $urandom();
        if ($urandom_range(0, 5) == 0) return corner_words[$urandom_range(0, 7)];
        if (cfg_kind == KIND_FLOAT) begin
            case ($urandom_range(0, 19))
                0, 1:    ex = 8'd0;
                2:       ex = FLT_EXP_SPEC;
                3:       ex = 8'($urandom_range(128, 254));
                default: ex = 8'($urandom_range(96, 127));
            endcase
            return {1'($urandom()), ex, 23'($urandom())};
        end
        amp = $urandom() >> $urandom_range(0, 31);
        return $urandom_range(0, 1) ? 32'd0 - amp : amp;
    endfunction

    task automatic queue_random_packets(input int unsigned n_beats);
        int unsigned made;
        int unsigned len;
        int unsigned k;
        logic        quiet_pkt;
        logic        burst;
        made = 0;
        while (made < n_beats) begin
            len       = ($urandom_range(0, 3) == 0) ? 1 : $urandom_range(2, 12);
            quiet_pkt = ($urandom_range(0, 7) == 0);
            burst     = tx_calm || ($urandom_range(0, 3) == 0);
            for (k = 0; k < len; k++) begin
                queue_beat(random_sample(), quiet_pkt || ($urandom_range(0, 19) == 0),
                           k == len - 1, burst ? 0 : $urandom_range(0, 6));
            end
            made += len;
        end
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Sender: advance to the next beat once the current one is taken
    always @(negedge i_clk) begin
        logic next_valid;
        if (!in_ch.valid || in_took) begin
            next_valid = 1'b0;
            if (!beat_held && beats_to_send.size() > 0) begin
                beat_now  = beats_to_send.pop_front();
                beat_held = 1'b1;
            end
            if (beat_held) begin
                if (beat_now.gap > 0) begin
                    beat_now.gap--;
                end else begin
                    next_valid = 1'b1;
                    beat_held  = 1'b0;
                    in_ch.raw_sample    <= beat_now.raw;
                    in_ch.packet_silent <= beat_now.silent;
                    in_ch.last_sample   <= beat_now.last;
                end
            end
            in_ch.valid <= next_valid;
        end
    end

    // Receiver: random stall per report, plus a long hold-off on request
    always @(negedge i_clk) begin
        if (rx_hold_req) begin
            rx_hold     = 300;
            rx_hold_req = 1'b0;
        end
        if (out_took) rx_stall = rx_calm ? 0 : $urandom_range(0, 6);
        if (rx_hold > 0) begin
            rx_hold--;
            out_ch.ready <= 1'b0;
        end else if (rx_stall > 0) begin
            rx_stall--;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_meter_report want;
        in_took  <= in_ch.valid && in_ch.ready;
        out_took <= out_ch.valid && out_ch.ready;
        if (i_rst_n) begin
            if (in_ch.valid && in_ch.ready) begin
                fold_sample(in_ch.raw_sample, in_ch.packet_silent, in_ch.last_sample);
                beats_taken++;
            end
            if (out_ch.valid && out_ch.ready) begin
                if (reports_due.size() == 0) begin
                    $error("report with nothing pending: packet_peak %h smoothed_level %h",
                           out_ch.packet_peak, out_ch.smoothed_level);
                    mismatches++;
                end else begin
                    want = reports_due.pop_front();
                    if (out_ch.packet_peak !== want.peak) begin
                        $error("packet_peak: expected %h, got %h",
                               want.peak, out_ch.packet_peak);
                        mismatches++;
                    end
                    if (out_ch.smoothed_level !== want.level) begin
                        $error("smoothed_level: expected %h, got %h",
                               want.level, out_ch.smoothed_level);
                        mismatches++;
                    end
                end
            end
        end
    end

    initial begin
        #3_000_000;
        $display("audio_packet_peak_level_meter: mismatch");
        $finish;
    end

    initial begin
        int unsigned phase;
        i_rst_n             = 1'b0;
        cfg_we              = 1'b0;
        cfg_index           = CFG_SAMPLE_KIND;
        cfg_data            = '0;
        in_ch.valid         = 1'b0;
        in_ch.raw_sample    = '0;
        in_ch.packet_silent = 1'b0;
        in_ch.last_sample   = 1'b0;
        out_ch.ready        = 1'b0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // PCM16 out of reset: high bits ignored, most negative code is full scale
        queue_beat(32'h0000_7FFF, 1'b0, 1'b0, $urandom_range(0, 6));
        queue_beat(32'hFFFF_8000, 1'b0, 1'b0, $urandom_range(0, 6));
        queue_beat(32'h0000_8000, 1'b1, 1'b0, $urandom_range(0, 6));
        queue_beat(32'h0000_0001, 1'b0, 1'b1, $urandom_range(0, 6));
        queue_beat(32'h1234_8000, 1'b1, 1'b1, $urandom_range(0, 6));

        // upper data bits of the kind register are dropped
        write_registers({4'b1111, KIND_PCM}, BPS_24);
        queue_beat(32'h007F_FFFF, 1'b0, 1'b0, $urandom_range(0, 6));
        queue_beat(32'hAB80_0000, 1'b0, 1'b0, $urandom_range(0, 6));
        queue_beat(32'h00FF_FFFF, 1'b0, 1'b1, $urandom_range(0, 6));

        write_registers({4'b0000, KIND_PCM}, BPS_32);
        queue_beat(32'h7FFF_FFFF, 1'b0, 1'b0, $urandom_range(0, 6));
        queue_beat(32'h8000_0000, 1'b0, 1'b0, $urandom_range(0, 6));
        queue_beat(32'hFFFF_FFFF, 1'b0, 1'b1, $urandom_range(0, 6));

        // float: subnormal, half, NaN; infinity; 2.0 saturates, -1.0
        write_registers({4'b0000, KIND_FLOAT}, BPS_32);
        queue_beat(32'h0040_0000, 1'b0, 1'b0, $urandom_range(0, 6));
        queue_beat(32'h3F00_0000, 1'b0, 1'b0, $urandom_range(0, 6));
        queue_beat(32'hFFC0_0000, 1'b0, 1'b1, $urandom_range(0, 6));
        queue_beat(32'h7F80_0000, 1'b0, 1'b1, $urandom_range(0, 6));
        queue_beat(32'h4000_0000, 1'b0, 1'b0, $urandom_range(0, 6));
        queue_beat(32'hBF80_0000, 1'b0, 1'b1, $urandom_range(0, 6));

        // unsupported combinations read as zero
        write_registers({4'b0000, KIND_FLOAT}, BPS_16);
        queue_beat(32'h3F80_0000, 1'b0, 1'b1, $urandom_range(0, 6));
        write_registers(6'h3F, 6'd63);
        queue_beat(32'hFFFF_FFFF, 1'b0, 1'b1, $urandom_range(0, 6));
        write_registers(6'd2, 6'd0);
        queue_beat(32'h8000_0000, 1'b0, 1'b1, $urandom_range(0, 6));

        for (phase = 0; phase < 8; phase++) begin
            case (phase)
                0:       write_registers({4'b0000, KIND_PCM}, BPS_16);
                1:       write_registers({4'b0000, KIND_PCM}, BPS_24);
                2:       write_registers({4'b0000, KIND_PCM}, BPS_32);
                3, 4:    write_registers({4'b0000, KIND_FLOAT}, BPS_32);
                5:       write_registers(6'($urandom()), pick_width());
                6:       write_registers({4'($urandom()), KIND_PCM}, pick_width());
                default: write_registers({4'b0000, KIND_PCM}, BPS_16);
            endcase
            tx_calm = (phase == 2);
            rx_calm = (phase == 2);
            // hold the receiver off while the sender keeps pushing
            if (phase == 1) rx_hold_req = 1'b1;
            if (phase == 3) begin
                queue_random_packets(65);
                wait_drained();
                @(posedge i_clk);
                queue_random_packets(65);
            end else begin
                queue_random_packets(130);
            end
        end

        wait_drained();
        if (mismatches == 0) begin
            $display("audio_packet_peak_level_meter: match");
        end else begin
            $display("audio_packet_peak_level_meter: mismatch");
        end
        $finish;
    end
endmodule
`default_nettype wire
